FILE: hw/rtl/sounding_slot_allocator_unit_macros.svh
// Assertion macros used by the checker file ssa_checker.sv.
`ifndef SOUNDING_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define SOUNDING_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ssa_pkg.sv
`default_nettype none
package ssa_pkg;

    localparam int MAC_W    = 48;
    localparam int AP_W     = 6;
    localparam int CLIENT_W = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int LIMIT_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd2;

    localparam logic [STAT_W-1:0] ST_ENABLED      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ALREADY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_ADDED        = 3'd2;
    localparam logic [STAT_W-1:0] ST_REFUSED      = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL         = 3'd4;
    localparam logic [STAT_W-1:0] ST_STOP_UNKNOWN = 3'd5;
    localparam logic [STAT_W-1:0] ST_STOP_PARTIAL = 3'd6;
    localparam logic [STAT_W-1:0] ST_STOPPED      = 3'd7;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STOP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT    = 1'd1;

    localparam logic [CLIENT_W-1:0] PRIORITY_MASK_RST = 32'd1;
    localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST    = 4'd8;

    typedef struct packed {
        logic [MAC_W-1:0]    mac;
        logic [AP_W-1:0]     ap;
        logic [CLIENT_W-1:0] subs;
    } entry_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [AP_W-1:0]   ap;
        logic [MAC_W-1:0]  mac;
        logic [STAT_W-1:0] status;
        logic              last;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ssa_ifs.sv
`default_nettype none
interface ssa_req_if;
    import ssa_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [AP_W-1:0]     req_ap_index;
    logic [MAC_W-1:0]    req_mac;
    logic [CLIENT_W-1:0] client_mask;

    modport source (output valid, kind, req_ap_index, req_mac, client_mask, input ready);
    modport sink (input valid, kind, req_ap_index, req_mac, client_mask, output ready);
endinterface

interface ssa_rsp_if;
    import ssa_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [AP_W-1:0]   out_ap_index;
    logic [MAC_W-1:0]  out_mac;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, action, out_ap_index, out_mac, status, last, input ready);
    modport sink (input valid, action, out_ap_index, out_mac, status, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ssa_ram.sv
`default_nettype none
module ssa_ram #(
    parameter int WIDTH = 86,
    parameter int DEPTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sounding_slot_allocator_unit.sv
// Sounding slot allocator.
// req channel (sink): one start or stop request per item, keyed by station MAC.
// rsp channel (source): one or two result items per request; last marks the
// final one. An eviction gives a disable item (last low) before the enable.
// cfg port: cfg_we/cfg_index/cfg_data write priority_client_mask (index 0) or
// slot_limit (index 1); write only while no request is in flight.
// Each request scans the slot memory, one entry per cycle over its read port,
// then updates at most one entry. The first result is loaded into the output
// register in S_OUT0, after S_SCAN, S_WAIT and S_DECIDE; S_OUT0 waits while
// the receiver stalls an item held there. A new request is taken only in
// S_IDLE, once every result of the previous one has been loaded. The next
// request is taken while the last result still waits in the output register.
// A stalled receiver holds the result; a second result or the next request's
// results wait until the output register drains.
// Reset (rst_n low, async) empties the table and restores the register
// defaults; the memory contents need no clearing, as invalid slots are ignored.
`default_nettype none
module sounding_slot_allocator_unit #(
    parameter int SLOTS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    ssa_req_if.sink                            req,
    ssa_rsp_if.source                          rsp,
    input  wire logic                          cfg_we,
    input  wire logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ssa_pkg::CLIENT_W-1:0]  cfg_data
);
    import ssa_pkg::*;

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int EW   = $bits(entry_t);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_OUT0   = 3'd4;
    localparam logic [2:0] S_OUT1   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       ctr_reg;
    logic                rd_pend_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CLIENT_W-1:0] pcm_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                kind_reg;
    logic [AP_W-1:0]     ap_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [CLIENT_W-1:0] cm_reg;

    logic                hit_found_reg, free_found_reg, vic_found_reg;
    logic [IW-1:0]       hit_idx_reg, free_idx_reg, vic_idx_reg;
    entry_t              hit_ent_reg, vic_ent_reg;

    result_t             res0_reg, res1_reg, res0_next, res1_next, out_reg;
    logic                two_reg, two_next;
    logic                out_valid_reg;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    entry_t              ram_wdata, rd_ent;
    logic [EW-1:0]       rd_bits;

    logic                rd_v;
    logic [CMPW-1:0]     lim_eff;
    logic                full;
    logic                out_free;
    logic [IW-1:0]       fr_idx;
    logic                accept;

    ssa_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ctr_reg),
        .rdata(rd_bits)
    );

    assign rd_ent   = entry_t'(rd_bits);
    assign rd_v     = valid_reg[rd_idx_reg];
    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.action       = out_reg.action;
    assign rsp.out_ap_index = out_reg.ap;
    assign rsp.out_mac      = out_reg.mac;
    assign rsp.status       = out_reg.status;
    assign rsp.last         = out_reg.last;

    assign lim_eff = (CMPW'(limit_reg) > CMPW'(SLOTS)) ? CMPW'(SLOTS) : CMPW'(limit_reg);
    assign full    = CMPW'(count_reg) >= lim_eff;
    assign fr_idx  = (free_found_reg && (free_idx_reg < vic_idx_reg)) ? free_idx_reg
                                                                      : vic_idx_reg;

    // request decision, applied in S_DECIDE
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = hit_idx_reg;
        ram_wdata  = hit_ent_reg;
        two_next   = 1'b0;
        res0_next  = '{action: ACT_NONE, ap: ap_reg, mac: mac_reg,
                       status: ST_FULL, last: 1'b1};
        res1_next  = '{action: ACT_ENABLE, ap: ap_reg, mac: mac_reg,
                       status: ST_ENABLED, last: 1'b1};
        if (kind_reg == KIND_STOP)
        begin
            if (!hit_found_reg)
            begin
                res0_next.status = ST_STOP_UNKNOWN;
            end
            else if ((hit_ent_reg.subs & ~cm_reg) != '0)
            begin
                ram_we              = 1'b1;
                ram_wdata.subs      = hit_ent_reg.subs & ~cm_reg;
                res0_next.status    = ST_STOP_PARTIAL;
            end
            else
            begin
                res0_next.action       = ACT_DISABLE;
                res0_next.ap           = hit_ent_reg.ap;
                res0_next.mac          = hit_ent_reg.mac;
                res0_next.status       = ST_STOPPED;
                valid_next[hit_idx_reg] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
        end
        else if (hit_found_reg)
        begin
            if ((hit_ent_reg.subs & cm_reg) != '0)
            begin
                res0_next.status = ST_ALREADY;
            end
            else
            begin
                ram_we           = 1'b1;
                ram_wdata.subs   = hit_ent_reg.subs | cm_reg;
                res0_next.status = ST_ADDED;
            end
        end
        else if (full)
        begin
            if (cm_reg != pcm_reg)
            begin
                res0_next.status = ST_REFUSED;
            end
            else if (vic_found_reg)
            begin
                res0_next.action  = ACT_DISABLE;
                res0_next.ap      = vic_ent_reg.ap;
                res0_next.mac     = vic_ent_reg.mac;
                res0_next.status  = ST_ENABLED;
                res0_next.last    = 1'b0;
                two_next          = 1'b1;
                valid_next[vic_idx_reg] = 1'b0;
                valid_next[fr_idx]      = 1'b1;
                ram_we            = 1'b1;
                ram_waddr         = fr_idx;
                ram_wdata         = '{mac: mac_reg, ap: ap_reg, subs: cm_reg};
                if (count_reg == '0)
                begin
                    count_next = CW'(1);
                end
            end
        end
        else if (free_found_reg)
        begin
            res0_next.action         = ACT_ENABLE;
            res0_next.status         = ST_ENABLED;
            valid_next[free_idx_reg] = 1'b1;
            ram_we                   = 1'b1;
            ram_waddr                = free_idx_reg;
            ram_wdata                = '{mac: mac_reg, ap: ap_reg, subs: cm_reg};
            count_next               = count_reg + CW'(1);
        end
        if (state_reg != S_DECIDE)
        begin
            ram_we = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (ctr_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_OUT0;
            S_OUT0:
            begin
                if (out_free)
                begin
                    state_next = two_reg ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ctr_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            pcm_reg        <= PRIORITY_MASK_RST;
            limit_reg      <= SLOT_LIMIT_RST;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_SCAN);
            if (cfg_we && cfg_index == CFG_PRIORITY_MASK)
            begin
                pcm_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_SLOT_LIMIT)
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
            if (accept)
            begin
                ctr_reg        <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                vic_found_reg  <= 1'b0;
            end
            else if (state_reg == S_SCAN && ctr_reg != IW'(SLOTS - 1))
            begin
                ctr_reg <= ctr_reg + IW'(1);
            end
            if (rd_pend_reg)
            begin
                if (rd_v && rd_ent.mac == mac_reg && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!rd_v && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (rd_v && (rd_ent.subs & ~pcm_reg) != '0 && !vic_found_reg)
                begin
                    vic_found_reg <= 1'b1;
                end
            end
            if (state_reg == S_DECIDE)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
            if ((state_reg == S_OUT0 || state_reg == S_OUT1) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= ctr_reg;
        if (accept)
        begin
            kind_reg <= req.kind;
            ap_reg   <= req.req_ap_index;
            mac_reg  <= req.req_mac;
            cm_reg   <= req.client_mask;
        end
        if (rd_pend_reg)
        begin
            if (rd_v && rd_ent.mac == mac_reg && !hit_found_reg)
            begin
                hit_idx_reg <= rd_idx_reg;
                hit_ent_reg <= rd_ent;
            end
            if (!rd_v && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_v && (rd_ent.subs & ~pcm_reg) != '0 && !vic_found_reg)
            begin
                vic_idx_reg <= rd_idx_reg;
                vic_ent_reg <= rd_ent;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            res0_reg <= res0_next;
            res1_reg <= res1_next;
            two_reg  <= two_next;
        end
        if (state_reg == S_OUT0 && out_free)
        begin
            out_reg <= res0_reg;
        end
        else if (state_reg == S_OUT1 && out_free)
        begin
            out_reg <= res1_reg;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ssa_checker.sv
`default_nettype none
`include "sounding_slot_allocator_unit_macros.svh"
module ssa_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [ssa_pkg::ACT_W-1:0]    rsp_action,
    input wire logic [ssa_pkg::AP_W-1:0]     rsp_ap,
    input wire logic [ssa_pkg::MAC_W-1:0]    rsp_mac,
    input wire logic [ssa_pkg::STAT_W-1:0]   rsp_status,
    input wire logic                         rsp_last
);
    import ssa_pkg::*;

    `SSA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_action) && $stable(rsp_ap) && $stable(rsp_mac)
        && $stable(rsp_status) && $stable(rsp_last), "stalled result item changed")
    `SSA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready,
        "request taken while another is in progress")
    `SSA_ASSERT_NOW(a_enable_final, clk, rst_n, rsp_valid && rsp_action == ACT_ENABLE,
        rsp_status == ST_ENABLED && rsp_last, "enable item not final or wrong status")
    `SSA_ASSERT_NOW(a_nonfinal_evict, clk, rst_n, rsp_valid && !rsp_last,
        rsp_action == ACT_DISABLE && rsp_status == ST_ENABLED,
        "non-final item is not an eviction")
    `SSA_ASSERT_NOW(a_disable_status, clk, rst_n, rsp_valid && rsp_action == ACT_DISABLE,
        rsp_status == ST_ENABLED || rsp_status == ST_STOPPED,
        "disable item with unexpected status")
endmodule

bind sounding_slot_allocator_unit ssa_checker u_ssa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_action(rsp.action),
    .rsp_ap    (rsp.out_ap_index),
    .rsp_mac   (rsp.out_mac),
    .rsp_status(rsp.status),
    .rsp_last  (rsp.last)
);
`default_nettype wire
